### src/r64arm_pkg.sv
package r64arm_pkg;

	// CRC-24 polynomial and seed
	localparam logic [23:0] CrcPoly = 24'h864CFB;
	localparam logic [23:0] CrcInit = 24'hB704CE;

	// Special characters
	localparam logic [6:0] PadChar = 7'h3D;
	localparam logic [6:0] NlChar  = 7'h0A;

	// Line length register: reset value and clamp limits
	localparam logic [6:0] LineBytesReset = 7'd48;
	localparam logic [6:0] LineBytesMin   = 7'd1;
	localparam logic [6:0] LineBytesMax   = 7'd96;

	// Saturation value of the line counter
	localparam logic [15:0] LineTotalMax = 16'hFFFF;

	// Register index codes (paddr[2])
	localparam logic RegLineBytes = 1'b0;
	localparam logic RegMaxLines  = 1'b1;

	// Job queue geometry
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// One job: what a single accepted word turns into, in emission order:
	// an optional group, an optional newline, an optional trailer.
	typedef struct packed {
		logic        grp_en;
		logic [23:0] grp_word;
		logic [1:0]  grp_cnt;
		logic        nl_en;
		logic        trl_en;
		logic [23:0] crc;
		logic [15:0] lines;
	} job_t;

	// Character steps of the back end
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_G0,
		ST_G1,
		ST_G2,
		ST_G3,
		ST_NL,
		ST_TEQ,
		ST_T0,
		ST_T1,
		ST_T2,
		ST_T3,
		ST_TNL
	} step_t;

	// Map a 6-bit value to its radix-64 character
	function automatic logic [6:0] alpha(input logic [5:0] v);
		logic [6:0] r;
		if (v < 6'd26) begin
			r = 7'h41 + {1'b0, v};
		end else if (v < 6'd52) begin
			r = 7'h61 + {1'b0, v} - 7'd26;
		end else if (v < 6'd62) begin
			r = 7'h30 + {1'b0, v} - 7'd52;
		end else if (v == 6'd62) begin
			r = 7'h2B;
		end else begin
			r = 7'h2F;
		end
		return r;
	endfunction

	// Advance the CRC-24 over one byte, MSB first
	function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
		logic [23:0] c;
		c = crc ^ {b, 16'h0000};
		for (int k = 0; k < 8; k++) begin
			if (c[23]) begin
				c = {c[22:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[22:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### src/radix64_armor_encoder_crc24.sv
// Radix-64 armor encoder with a CRC-24 trailer. Each input word may carry one data
// byte and an end-of-data mark; each output word carries one character. The front
// end takes one input word per clock while its four-entry job queue has room, and
// the back end emits one character per clock while the output is not stalled. An
// input word produces 0 to 11 characters, on average about 1.4 per data byte with
// 64-character lines. The back end's one-character-per-clock output register sets
// the sustained rate. The first character a word causes passes through the job
// queue and then the output register before it appears on the output.
// Registers: line_bytes at byte address 0 (reset 48, 0 acts as 1, above 96 acts
// as 96), max_lines at byte address 4 (0 = no limit).
module radix64_armor_encoder_crc24 (
	input  logic         clk,
	input  logic         arst_n,
	// input channel
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [7:0]   data_byte,
	input  logic         has_byte,
	input  logic         end_of_data,
	// output channel
	output logic         out_valid,
	input  logic         out_stall,
	output logic [6:0]   char_out,
	output logic         run_last,
	output logic         armor_done,
	output logic [15:0]  lines_done,
	// configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [6:0]        line_bytes_q;
	logic [15:0]       max_lines_q;
	logic              cfg_wr;
	logic              push;
	logic              pop;
	logic              q_nonempty;
	logic              q_full;
	r64arm_pkg::job_t  push_job;
	r64arm_pkg::job_t  head_job;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q <= r64arm_pkg::LineBytesReset;
			max_lines_q  <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == r64arm_pkg::RegLineBytes) begin
				line_bytes_q <= pwdata[6:0];
			end else begin
				max_lines_q <= pwdata[15:0];
			end
		end
	end

	assign prdata = (paddr[2] == r64arm_pkg::RegMaxLines) ?
		{16'h0000, max_lines_q} : {25'h0, line_bytes_q};

	r64arm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.has_byte    (has_byte),
		.end_of_data (end_of_data),
		.line_bytes  (line_bytes_q),
		.max_lines   (max_lines_q),
		.q_full      (q_full),
		.push        (push),
		.push_job    (push_job)
	);

	r64arm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.q_nonempty (q_nonempty),
		.q_full     (q_full),
		.head_job   (head_job)
	);

	r64arm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_out   (char_out),
		.run_last   (run_last),
		.armor_done (armor_done),
		.lines_done (lines_done)
	);

endmodule

### src/r64arm_front.sv
module r64arm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  logic                  has_byte,
	input  logic                  end_of_data,
	input  logic [6:0]            line_bytes,
	input  logic [15:0]           max_lines,
	input  logic                  q_full,
	output logic                  push,
	output r64arm_pkg::job_t      push_job
);

	logic [23:0] crc_q;
	logic [15:0] grp_bits_q;
	logic [1:0]  grp_fill_q;
	logic [6:0]  line_fill_q;
	logic [15:0] line_total_q;
	logic        limit_q;

	logic [23:0] crc_d;
	logic [15:0] grp_bits_d;
	logic [1:0]  grp_fill_d;
	logic [6:0]  line_fill_d;
	logic [15:0] line_total_d;
	logic        limit_d;
	logic [6:0]  eff;
	logic        acc;
	r64arm_pkg::job_t job;

	// Hold the input while the job queue is full
	assign in_stall = q_full;
	assign acc      = in_valid && !q_full;

	// Classify the word: update the running state and build its job
	always_comb begin
		crc_d        = crc_q;
		grp_bits_d   = grp_bits_q;
		grp_fill_d   = grp_fill_q;
		line_fill_d  = line_fill_q;
		line_total_d = line_total_q;
		limit_d      = limit_q;
		job          = '0;

		if (line_bytes == 7'd0) begin
			eff = r64arm_pkg::LineBytesMin;
		end else if (line_bytes > r64arm_pkg::LineBytesMax) begin
			eff = r64arm_pkg::LineBytesMax;
		end else begin
			eff = line_bytes;
		end

		if (!limit_q) begin
			if (has_byte) begin
				crc_d = r64arm_pkg::crc_byte(crc_q, data_byte);
				unique case (grp_fill_q)
					2'd0: begin
						grp_bits_d = {data_byte, 8'h00};
						grp_fill_d = 2'd1;
					end
					2'd1: begin
						grp_bits_d = {grp_bits_q[15:8], data_byte};
						grp_fill_d = 2'd2;
					end
					default: begin
						job.grp_en   = 1'b1;
						job.grp_word = {grp_bits_q, data_byte};
						job.grp_cnt  = 2'd3;
						grp_bits_d   = '0;
						grp_fill_d   = 2'd0;
					end
				endcase
				line_fill_d = line_fill_q + 7'd1;
				// Close the line once it is full
				if (line_fill_d >= eff) begin
					if (grp_fill_d != 2'd0) begin
						job.grp_en   = 1'b1;
						job.grp_word = {grp_bits_d, 8'h00};
						job.grp_cnt  = grp_fill_d;
					end
					grp_bits_d  = '0;
					grp_fill_d  = 2'd0;
					job.nl_en   = 1'b1;
					if (line_total_d != r64arm_pkg::LineTotalMax) begin
						line_total_d = line_total_d + 16'd1;
					end
					line_fill_d = '0;
					// Stop at the line limit
					if (max_lines != 16'd0 && line_total_d == max_lines) begin
						job.trl_en = 1'b1;
						job.crc    = crc_d;
						job.lines  = line_total_d;
						limit_d    = 1'b1;
					end
				end
			end
			// Flush a partial line, then the trailer
			if (end_of_data && !limit_d) begin
				if (line_fill_d != 7'd0) begin
					if (grp_fill_d != 2'd0) begin
						job.grp_en   = 1'b1;
						job.grp_word = {grp_bits_d, 8'h00};
						job.grp_cnt  = grp_fill_d;
					end
					job.nl_en = 1'b1;
					if (line_total_d != r64arm_pkg::LineTotalMax) begin
						line_total_d = line_total_d + 16'd1;
					end
				end
				job.trl_en = 1'b1;
				job.crc    = crc_d;
				job.lines  = line_total_d;
			end
		end

		// Restart after end of data
		if (end_of_data) begin
			crc_d        = r64arm_pkg::CrcInit;
			grp_bits_d   = '0;
			grp_fill_d   = 2'd0;
			line_fill_d  = '0;
			line_total_d = '0;
			limit_d      = 1'b0;
		end
	end

	assign push     = acc && (job.grp_en || job.nl_en || job.trl_en);
	assign push_job = job;

	// Advance the running state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= r64arm_pkg::CrcInit;
			grp_bits_q   <= '0;
			grp_fill_q   <= 2'd0;
			line_fill_q  <= '0;
			line_total_q <= '0;
			limit_q      <= 1'b0;
		end else if (acc) begin
			crc_q        <= crc_d;
			grp_bits_q   <= grp_bits_d;
			grp_fill_q   <= grp_fill_d;
			line_fill_q  <= line_fill_d;
			line_total_q <= line_total_d;
			limit_q      <= limit_d;
		end
	end

endmodule

### src/r64arm_queue.sv
module r64arm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  r64arm_pkg::job_t      push_job,
	input  logic                  pop,
	output logic                  q_nonempty,
	output logic                  q_full,
	output r64arm_pkg::job_t      head_job
);

	r64arm_pkg::job_t                 mem_q [r64arm_pkg::QDepth];
	logic [r64arm_pkg::QPtrW-1:0]     wr_ptr_q;
	logic [r64arm_pkg::QPtrW-1:0]     rd_ptr_q;
	logic [r64arm_pkg::QCntW-1:0]     count_q;
	logic                             do_push;
	logic                             do_pop;

	assign q_nonempty = (count_q != '0);
	assign q_full     = (count_q == r64arm_pkg::QCntW'(r64arm_pkg::QDepth));
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && !q_full;
	assign do_pop     = pop && q_nonempty;

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### src/r64arm_back.sv
module r64arm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_nonempty,
	input  r64arm_pkg::job_t      head_job,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [6:0]            char_out,
	output logic                  run_last,
	output logic                  armor_done,
	output logic [15:0]           lines_done
);

	r64arm_pkg::step_t step_q;
	r64arm_pkg::step_t step_d;
	r64arm_pkg::step_t cur;
	r64arm_pkg::step_t nxt;
	logic              out_valid_q;
	logic [6:0]        char_q;
	logic              last_q;
	logic              done_q;
	logic [15:0]       lines_q;
	logic              load;
	logic              fire;
	logic              last;
	logic [6:0]        ch;
	logic [5:0]        sextet;
	logic              done;

	assign load = !out_valid_q || !out_stall;
	assign fire = q_nonempty && load;

	// Pick the current character step, the next one, and the character
	always_comb begin
		if (step_q == r64arm_pkg::ST_IDLE) begin
			if (head_job.grp_en) begin
				cur = r64arm_pkg::ST_G0;
			end else if (head_job.nl_en) begin
				cur = r64arm_pkg::ST_NL;
			end else begin
				cur = r64arm_pkg::ST_TEQ;
			end
		end else begin
			cur = step_q;
		end

		nxt    = r64arm_pkg::ST_IDLE;
		ch     = r64arm_pkg::NlChar;
		sextet = '0;
		done   = 1'b0;
		unique case (cur)
			r64arm_pkg::ST_G0: begin
				nxt = r64arm_pkg::ST_G1;
				ch  = r64arm_pkg::alpha(head_job.grp_word[23:18]);
			end
			r64arm_pkg::ST_G1: begin
				nxt = r64arm_pkg::ST_G2;
				ch  = r64arm_pkg::alpha(head_job.grp_word[17:12]);
			end
			r64arm_pkg::ST_G2: begin
				nxt = r64arm_pkg::ST_G3;
				ch  = (head_job.grp_cnt >= 2'd2) ?
					r64arm_pkg::alpha(head_job.grp_word[11:6]) : r64arm_pkg::PadChar;
			end
			r64arm_pkg::ST_G3: begin
				if (head_job.nl_en) begin
					nxt = r64arm_pkg::ST_NL;
				end else if (head_job.trl_en) begin
					nxt = r64arm_pkg::ST_TEQ;
				end
				ch = (head_job.grp_cnt == 2'd3) ?
					r64arm_pkg::alpha(head_job.grp_word[5:0]) : r64arm_pkg::PadChar;
			end
			r64arm_pkg::ST_NL: begin
				if (head_job.trl_en) begin
					nxt = r64arm_pkg::ST_TEQ;
				end
				ch = r64arm_pkg::NlChar;
			end
			r64arm_pkg::ST_TEQ: begin
				nxt = r64arm_pkg::ST_T0;
				ch  = r64arm_pkg::PadChar;
			end
			r64arm_pkg::ST_T0: begin
				nxt    = r64arm_pkg::ST_T1;
				sextet = head_job.crc[23:18];
				ch     = r64arm_pkg::alpha(sextet);
			end
			r64arm_pkg::ST_T1: begin
				nxt    = r64arm_pkg::ST_T2;
				sextet = head_job.crc[17:12];
				ch     = r64arm_pkg::alpha(sextet);
			end
			r64arm_pkg::ST_T2: begin
				nxt    = r64arm_pkg::ST_T3;
				sextet = head_job.crc[11:6];
				ch     = r64arm_pkg::alpha(sextet);
			end
			r64arm_pkg::ST_T3: begin
				nxt    = r64arm_pkg::ST_TNL;
				sextet = head_job.crc[5:0];
				ch     = r64arm_pkg::alpha(sextet);
			end
			r64arm_pkg::ST_TNL: begin
				ch   = r64arm_pkg::NlChar;
				done = 1'b1;
			end
			default: begin
				nxt = r64arm_pkg::ST_IDLE;
			end
		endcase

		last   = (nxt == r64arm_pkg::ST_IDLE);
		step_d = step_q;
		if (fire) begin
			step_d = nxt;
		end
	end

	// Drop the job from the queue after its last character
	assign pop = fire && last;

	// Hold the step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= r64arm_pkg::ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			char_q  <= ch;
			last_q  <= last;
			done_q  <= done;
			lines_q <= done ? head_job.lines : 16'd0;
		end
	end

	assign out_valid  = out_valid_q;
	assign char_out   = char_q;
	assign run_last   = last_q;
	assign armor_done = done_q;
	assign lines_done = lines_q;

endmodule

### src/r64arm_checker.sv
module r64arm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         out_valid,
	input logic         out_stall,
	input logic [6:0]   char_out,
	input logic         run_last,
	input logic         armor_done,
	input logic [15:0]  lines_done
);

	// A stalled output word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// The trailer ends in a newline
	a_done_nl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && armor_done |-> char_out == r64arm_pkg::NlChar)
		else $error("armor_done on a character other than newline");

	// The trailer newline closes its input word
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && armor_done |-> run_last)
		else $error("armor_done without run_last");

	// The line count shows only with the trailer newline
	a_lines_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !armor_done |-> lines_done == 16'd0)
		else $error("lines_done nonzero outside the trailer");

endmodule

bind radix64_armor_encoder_crc24 r64arm_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.char_out   (char_out),
	.run_last   (run_last),
	.armor_done (armor_done),
	.lines_done (lines_done)
);

### tb/radix64_armor_encoder_crc24_tb.sv
// One expected output character
typedef struct packed {
	logic [6:0]  ch;
	logic        last;
	logic        done;
	logic [15:0] lines;
} armor_char_t;

// Armor predictor and character queue
class armor_scoreboard;
	localparam logic [6:0]  EqualsChar  = 7'h3D;
	localparam logic [6:0]  NewlineChar = 7'h0A;
	localparam logic [23:0] Crc24Poly   = 24'h864CFB;
	localparam logic [23:0] Crc24Seed   = 24'hB704CE;

	logic [6:0]  line_bytes;
	logic [15:0] max_lines;
	logic [23:0] crc;
	logic [15:0] grp_bits;
	logic [1:0]  grp_fill;
	logic [6:0]  line_fill;
	logic [15:0] line_total;
	logic        stopped;
	armor_char_t burst[$];
	armor_char_t pending[$];
	int          errors;
	int          words;
	int          chars;
	int          trailers;

	function new();
		line_bytes = 7'd48;
		max_lines  = 16'd0;
		errors     = 0;
		words      = 0;
		chars      = 0;
		trailers   = 0;
		clear_msg();
	endfunction

	function void clear_msg();
		crc        = Crc24Seed;
		grp_bits   = 16'd0;
		grp_fill   = 2'd0;
		line_fill  = 7'd0;
		line_total = 16'd0;
		stopped    = 1'b0;
	endfunction

	function void set_reg(logic idx, logic [31:0] v);
		if (idx == r64arm_pkg::RegLineBytes) begin
			line_bytes = v[6:0];
		end else begin
			max_lines = v[15:0];
		end
	endfunction

	function logic [6:0] radix_char(logic [5:0] v);
		string digits;
		byte   c;
		digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		c = digits[v];
		return c[6:0];
	endfunction

	// Fold one byte into the CRC, MSB first
	function void fold_crc(logic [7:0] b);
		logic [24:0] c;
		c = {1'b0, crc ^ {b, 16'h0000}};
		for (int k = 0; k < 8; k++) begin
			c = {c[23:0], 1'b0};
			if (c[24]) begin
				c[23:0] = c[23:0] ^ Crc24Poly;
			end
			c[24] = 1'b0;
		end
		crc = c[23:0];
	endfunction

	function void put_char(logic [6:0] ch, logic done);
		armor_char_t a;
		a.ch    = ch;
		a.last  = 1'b0;
		a.done  = done;
		a.lines = done ? line_total : 16'd0;
		burst.push_back(a);
	endfunction

	function void put_group(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, int cnt);
		logic [23:0] w;
		w = {b0, b1, b2};
		put_char(radix_char(w[23:18]), 1'b0);
		put_char(radix_char(w[17:12]), 1'b0);
		put_char(cnt >= 2 ? radix_char(w[11:6]) : EqualsChar, 1'b0);
		put_char(cnt >= 3 ? radix_char(w[5:0]) : EqualsChar, 1'b0);
	endfunction

	// Flush a partial group, close the line, count it
	function void close_line();
		if (grp_fill > 0) begin
			put_group(grp_bits[15:8], grp_bits[7:0], 8'h00, grp_fill);
		end
		grp_bits = 16'd0;
		grp_fill = 2'd0;
		put_char(NewlineChar, 1'b0);
		if (line_total != 16'hFFFF) begin
			line_total = line_total + 16'd1;
		end
		line_fill = 7'd0;
	endfunction

	function void put_trailer();
		put_char(EqualsChar, 1'b0);
		put_group(crc[23:16], crc[15:8], crc[7:0], 3);
		put_char(NewlineChar, 1'b1);
		trailers++;
	endfunction

	// Work out the characters caused by one accepted word
	function void note_word(logic [7:0] b, logic hb, logic eod);
		logic [6:0] eff;
		words++;
		burst.delete();
		eff = line_bytes;
		if (eff == 7'd0) begin
			eff = 7'd1;
		end
		if (eff > 7'd96) begin
			eff = 7'd96;
		end
		if (!stopped) begin
			if (hb) begin
				fold_crc(b);
				case (grp_fill)
					2'd0: begin
						grp_bits = {b, 8'h00};
						grp_fill = 2'd1;
					end
					2'd1: begin
						grp_bits[7:0] = b;
						grp_fill = 2'd2;
					end
					default: begin
						put_group(grp_bits[15:8], grp_bits[7:0], b, 3);
						grp_bits = 16'd0;
						grp_fill = 2'd0;
					end
				endcase
				line_fill = line_fill + 7'd1;
				if (line_fill >= eff) begin
					close_line();
					if (max_lines != 16'd0 && line_total == max_lines) begin
						put_trailer();
						stopped = 1'b1;
					end
				end
			end
			if (eod && !stopped) begin
				if (line_fill > 0) begin
					close_line();
				end
				put_trailer();
			end
		end
		if (eod) begin
			clear_msg();
		end
		if (burst.size() > 0) begin
			burst[burst.size() - 1].last = 1'b1;
		end
		foreach (burst[i]) begin
			pending.push_back(burst[i]);
		end
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 40) begin
			$display("MISMATCH: %s", msg);
		end
	endtask

	// Compare one accepted character with the oldest expectation
	task check_char(logic [6:0] ch, logic last, logic done, logic [15:0] lines);
		armor_char_t exp_c;
		chars++;
		if (pending.size() == 0) begin
			report($sformatf("unexpected char %02h (last=%0b done=%0b)", ch, last, done));
			return;
		end
		exp_c = pending.pop_front();
		if (ch !== exp_c.ch || last !== exp_c.last || done !== exp_c.done ||
				lines !== exp_c.lines) begin
			report($sformatf("char %0d: got %02h/%0b/%0b/%0d want %02h/%0b/%0b/%0d",
				chars, ch, last, done, lines, exp_c.ch, exp_c.last, exp_c.done,
				exp_c.lines));
		end
	endtask
endclass

module radix64_armor_encoder_crc24_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DrainCycles  = 12;
	localparam int HoldCycles   = 300;
	localparam int PhaseWords   = 16;
	localparam int HoldWords    = 24;
	localparam int NumPhases    = 8;
	localparam int PhaseLb[NumPhases]   = '{3, 1, 0, 127, 5, 96, 2, 7};
	localparam int PhaseMl[NumPhases]   = '{0, 2, 0, 0, 65535, 1, 3, 0};
	localparam int PhaseIdle[NumPhases] = '{0, 86, 0, 37, 0, 86, 0, 37};
	localparam int PhaseStall[NumPhases] = '{0, 0, 86, 37, 0, 0, 86, 37};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        end_of_data = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [6:0]  char_out;
	logic        run_last;
	logic        armor_done;
	logic [15:0] lines_done;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	armor_scoreboard sb;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int stim_words = 0;
	bit hold_req = 1'b0;
	int holds_done = 0;

	radix64_armor_encoder_crc24 u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.has_byte   (has_byte),
		.end_of_data(end_of_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_out   (char_out),
		.run_last   (run_last),
		.armor_done (armor_done),
		.lines_done (lines_done),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #2 clk = ~clk;

	// Sample both channels at the edge
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			sb.note_word(data_byte, has_byte, end_of_data);
		end
		if (arst_n && out_valid && !out_stall) begin
			sb.check_char(char_out, run_last, armor_done, lines_done);
		end
	end

	// Receiver: random stall, or a long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				holds_done++;
				repeat (HoldCycles) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Offer one word, hold it until taken, then idle at random
	task automatic send_word(logic [7:0] b, logic hb, logic eod);
		data_byte   <= b;
		has_byte    <= hb;
		end_of_data <= eod;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (hb || eod) begin
			stim_words++;
		end
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Wait until every expected character is out, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// A message of random bytes, with some idle words mixed in
	task automatic send_message(int nbytes, bit open_end);
		bit glue;
		glue = $urandom_range(1);
		for (int i = 0; i < nbytes; i++) begin
			if ($urandom_range(15) == 0) begin
				send_word(pick_byte(), 1'b0, 1'b0);
			end
			send_word(pick_byte(), 1'b1, !open_end && glue && i == nbytes - 1);
		end
		if (!open_end && !(glue && nbytes > 0)) begin
			send_word(pick_byte(), 1'b0, 1'b1);
		end
	endtask

	task automatic send_messages(int nwords);
		int stop_at;
		int len;
		stop_at = stim_words + nwords;
		while (stim_words < stop_at) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 20);
			send_message(len, 1'b0);
		end
		// leave a line open now and then, so the next settings apply mid-line
		if ($urandom_range(1)) begin
			send_message($urandom_range(1, 5), 1'b1);
		end
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message: trailer alone
		send_word(8'hA5, 1'b0, 1'b1);
		// full group of extreme bytes, separate end marker
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'hFF, 1'b1, 1'b0);
		send_word(8'h80, 1'b1, 1'b0);
		send_word(8'h5A, 1'b0, 1'b1);
		// byte together with end of data: two pads
		send_word(8'h7F, 1'b1, 1'b1);
		// word with neither flag does nothing
		send_word(8'hC3, 1'b0, 1'b0);
		// two bytes: one pad
		send_word(8'h01, 1'b1, 1'b0);
		send_word(8'hFE, 1'b1, 1'b1);
		drain();

		// zero line length acts as one byte per line
		write_reg(r64arm_pkg::RegLineBytes, 32'd0);
		send_word(8'h55, 1'b1, 1'b0);
		send_word(8'hAA, 1'b1, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);
		drain();

		// line limit: later bytes dropped, end marker restarts silently
		write_reg(r64arm_pkg::RegLineBytes, 32'd2);
		write_reg(r64arm_pkg::RegMaxLines, 32'd1);
		send_word(8'h12, 1'b1, 1'b0);
		send_word(8'h34, 1'b1, 1'b0);
		send_word(8'h56, 1'b1, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);
		drain();

		// shorten the line while one is open
		write_reg(r64arm_pkg::RegMaxLines, 32'd0);
		write_reg(r64arm_pkg::RegLineBytes, 32'd6);
		repeat (4) send_word(pick_byte(), 1'b1, 1'b0);
		drain();
		write_reg(r64arm_pkg::RegLineBytes, 32'd2);
		send_word(pick_byte(), 1'b1, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);
		drain();

		// limit already below the line count never fires
		write_reg(r64arm_pkg::RegLineBytes, 32'd1);
		repeat (3) send_word(pick_byte(), 1'b1, 1'b0);
		drain();
		write_reg(r64arm_pkg::RegMaxLines, 32'd2);
		repeat (2) send_word(pick_byte(), 1'b1, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);
		drain();

		// random phases over several settings and idling patterns
		for (int p = 0; p < NumPhases; p++) begin
			drain();
			write_reg(r64arm_pkg::RegLineBytes, 32'(PhaseLb[p]));
			write_reg(r64arm_pkg::RegMaxLines, 32'(PhaseMl[p]));
			sender_idle_pct = PhaseIdle[p];
			recv_stall_pct  = PhaseStall[p];
			send_messages(PhaseWords);
			if (p == 3) begin
				// long output hold while the sender keeps offering words
				drain();
				write_reg(r64arm_pkg::RegLineBytes, 32'd4);
				write_reg(r64arm_pkg::RegMaxLines, 32'd0);
				sender_idle_pct = 0;
				recv_stall_pct  = 0;
				hold_req = 1'b1;
				send_messages(HoldWords);
			end
		end

		sender_idle_pct = 0;
		drain();
		recv_stall_pct = 0;
		repeat (DrainCycles) @(posedge clk);

		$display("Checked %0d characters from %0d words, %0d trailers, %0d long holds.",
			sb.chars, sb.words, sb.trailers, holds_done);
		$display("Covered line lengths 0 to 127, line limits 0 to 65535 and stalls on both sides.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
